/* rtl/gain_ranging_quantizer_assert.svh */
// Assertion macros for the gain ranging quantizer.
`ifndef GAIN_RANGING_QUANTIZER_ASSERT_SVH
`define GAIN_RANGING_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define GRQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GRQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRQ_ASSERT(label, clk, rst, prop, msg)
`define GRQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/grq_pkg.sv */
`default_nettype none
package grq_pkg;
  localparam int GAIN_REGS = 4;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  localparam logic [2:0] REG_LEVEL  = 3'd0;
  localparam logic [2:0] REG_MBITS  = 3'd1;
  localparam logic [2:0] REG_GCOUNT = 3'd2;
  localparam logic [2:0] REG_GAIN0  = 3'd3;
  localparam logic [2:0] REG_GAIN1  = 3'd4;
  localparam logic [2:0] REG_GAIN2  = 3'd5;
  localparam logic [2:0] REG_GAIN3  = 3'd6;

  typedef struct packed {
    logic [38:0]                 den;
    logic [GAIN_REGS-1:0][7:0]   g;
    logic [22:0]                 irange;
    logic [2:0]                  n;
  } cfg_t;
endpackage
`default_nettype wire

/* rtl/gain_ranging_quantizer.sv */
// Throughput: one transaction per cycle while out_ready does not stall
// the output; the two pipelined divider stages (a divider of 24 quotient
// bits per gain lane, then one of 32; one bit per stage) set the depth.
// Reset: clears all stage valid bits and the clip counter, and loads the
// default configuration (level 1.0, 14 bits, gains 128, 32, 8, 1).
`default_nettype none
`include "gain_ranging_quantizer_assert.svh"
module gain_ranging_quantizer #(
  parameter int NUM_GAINS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] sample,
  input  logic               last_in_record,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] quantized,
  output logic signed [24:0] code,
  output logic [1:0]         gain_index,
  output logic               clipped,
  output logic [23:0]        clip_count,
  output logic               record_end
);
  import grq_pkg::*;

  localparam int LANES = (NUM_GAINS < GAIN_REGS) ? NUM_GAINS : GAIN_REGS;
  localparam int SW2   = 53;

  cfg_t cfg;
  logic adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  grq_cfg #(.LANES(LANES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic        a_vld, a_neg, a_last;
  logic [31:0] a_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg  <= sample[31];
      a_last <= last_in_record;
      a_mag  <= sample[31] ? 32'(-sample) : 32'(sample);
    end
  end

  logic        b_vld, b_neg, b_last;
  logic [39:0] b_prod [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_neg  <= a_neg;
      b_last <= a_last;
      for (int i = 0; i < LANES; i++) begin
        b_prod[i] <= 40'(a_mag) * 40'(cfg.g[i]);
      end
    end
  end

  logic        d1_vld;
  logic [1:0]  d1_side;
  logic [23:0] d1_q   [LANES];
  logic        d1_ovf [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [63:0] num1;
    assign num1 = {23'd0, b_prod[i], 1'b0} + 64'(cfg.den);
    if (i == 0) begin : g_head
      grq_div #(.QW(24), .SW(2)) u_div (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .in_valid  (b_vld),
        .num       (num1),
        .den       ({24'd0, cfg.den, 1'b0}),
        .side      ({b_neg, b_last}),
        .out_valid (d1_vld),
        .quo       (d1_q[i]),
        .ovf       (d1_ovf[i]),
        .side_out  (d1_side)
      );
    end else begin : g_tail
      grq_div #(.QW(24), .SW(2)) u_div (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .in_valid  (b_vld),
        .num       (num1),
        .den       ({24'd0, cfg.den, 1'b0}),
        .side      ({b_neg, b_last}),
        .out_valid (),
        .quo       (d1_q[i]),
        .ovf       (d1_ovf[i]),
        .side_out  ()
      );
    end
  end

  logic        found, sel_clip;
  logic [23:0] sel_q;
  logic [1:0]  sel_idx, fit_idx;
  logic [7:0]  sel_gdiv;
  logic [23:0] cnt, cnt_inc;

  always_comb begin
    found   = 1'b0;
    fit_idx = '0;
    sel_q   = '0;
    for (int i = 0; i < LANES; i++) begin
      if (!found && (3'(i) < cfg.n) && !d1_ovf[i] && (d1_q[i] <= {1'b0, cfg.irange})) begin
        found   = 1'b1;
        fit_idx = 2'(i);
        sel_q   = d1_q[i];
      end
    end
    sel_clip = !found;
    if (sel_clip) begin
      sel_q    = {1'b0, cfg.irange} + 24'd1;
      sel_idx  = 2'(cfg.n - 3'd1);
      sel_gdiv = 8'd1;
    end else begin
      sel_idx  = fit_idx;
      sel_gdiv = cfg.g[fit_idx];
    end
    cnt_inc = (sel_clip && cnt != COUNT_MAX) ? cnt + 24'd1 : cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (adv && d1_vld) begin
      cnt <= d1_side[0] ? '0 : cnt_inc;
    end
  end

  logic        c_vld, c_neg, c_last, c_clip;
  logic [23:0] c_q, c_cnt;
  logic [1:0]  c_idx;
  logic [7:0]  c_gdiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg  <= d1_side[1];
      c_last <= d1_side[0];
      c_clip <= sel_clip;
      c_q    <= sel_q;
      c_cnt  <= cnt_inc;
      c_idx  <= sel_idx;
      c_gdiv <= sel_gdiv;
    end
  end

  logic        d_vld, d_neg, d_last, d_clip;
  logic [23:0] d_q, d_cnt;
  logic [1:0]  d_idx;
  logic [7:0]  d_gdiv;
  logic [43:0] d_pplo;
  logic [42:0] d_pphi;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_neg  <= c_neg;
      d_last <= c_last;
      d_clip <= c_clip;
      d_q    <= c_q;
      d_cnt  <= c_cnt;
      d_idx  <= c_idx;
      d_gdiv <= c_gdiv;
      d_pplo <= 44'(c_q) * 44'(cfg.den[19:0]);
      d_pphi <= 43'(c_q) * 43'(cfg.den[38:20]);
    end
  end

  logic        e_vld, e_neg, e_last, e_clip;
  logic [23:0] e_q, e_cnt;
  logic [1:0]  e_idx;
  logic [7:0]  e_gdiv;
  logic [63:0] e_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_neg  <= d_neg;
      e_last <= d_last;
      e_clip <= d_clip;
      e_q    <= d_q;
      e_cnt  <= d_cnt;
      e_idx  <= d_idx;
      e_gdiv <= d_gdiv;
      e_rec  <= (64'(d_pphi) << 20) + 64'(d_pplo);
    end
  end

  logic           d2_vld, d2_ovf;
  logic [31:0]    d2_q;
  logic [SW2-1:0] d2_side;

  grq_div #(.QW(32), .SW(SW2)) u_recon (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (e_vld),
    .num       ({e_rec[62:0], 1'b0} + 64'(e_gdiv)),
    .den       ({55'd0, e_gdiv, 1'b0}),
    .side      ({e_neg, e_last, e_clip, e_cnt, e_q, e_idx}),
    .out_valid (d2_vld),
    .quo       (d2_q),
    .ovf       (d2_ovf),
    .side_out  (d2_side)
  );

  logic        f_neg;
  logic [23:0] f_q;
  logic [31:0] r_fin;

  assign f_neg = d2_side[52];
  assign f_q   = d2_side[25:2];

  always_comb begin
    if (f_neg) begin
      r_fin = (d2_ovf || d2_q > 32'h80000000) ? 32'h80000000 : d2_q;
    end else begin
      r_fin = (d2_ovf || d2_q[31]) ? 32'h7FFFFFFF : d2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quantized  <= f_neg ? -$signed(r_fin) : $signed(r_fin);
      code       <= f_neg ? -$signed({1'b0, f_q}) : $signed({1'b0, f_q});
      gain_index <= d2_side[1:0];
      clipped    <= d2_side[50];
      clip_count <= d2_side[49:26];
      record_end <= d2_side[51];
    end
  end

  `GRQ_ASSERT(a_clip_idx, clk, rst, out_valid && clipped |-> gain_index == 2'(cfg.n - 3'd1), "clipped result not on last gain")
  `GRQ_ASSERT(a_zero_code, clk, rst, out_valid && code == '0 |-> quantized == '0, "zero code with nonzero reconstruction")
  `GRQ_ASSERT(a_clip_cnt, clk, rst, out_valid && clipped |-> clip_count != '0, "clipped result with zero clip count")
  `GRQ_ASSERT_RST(a_rst_idle, clk, rst |=> !out_valid, "output valid right after reset")
endmodule
`default_nettype wire

/* rtl/grq_cfg.sv */
`default_nettype none
module grq_cfg #(
  parameter int LANES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output grq_pkg::cfg_t cfg
);
  import grq_pkg::*;

  logic [30:0] level;
  logic [4:0]  mbits;
  logic [2:0]  gcount;
  logic [7:0]  gain [GAIN_REGS];
  logic [30:0] lv;
  logic [4:0]  m_sat;
  logic [23:0] range_full;
  logic [38:0] den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= 31'd65536;
      mbits   <= 5'd14;
      gcount  <= 3'd4;
      gain[0] <= 8'd128;
      gain[1] <= 8'd32;
      gain[2] <= 8'd8;
      gain[3] <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEVEL:  level   <= cfg_data[30:0];
        REG_MBITS:  mbits   <= cfg_data[4:0];
        REG_GCOUNT: gcount  <= cfg_data[2:0];
        REG_GAIN0:  gain[0] <= cfg_data[7:0];
        REG_GAIN1:  gain[1] <= cfg_data[7:0];
        REG_GAIN2:  gain[2] <= cfg_data[7:0];
        REG_GAIN3:  gain[3] <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lv = (level == '0) ? 31'd1 : level;
    if (mbits < 5'd2) begin
      m_sat = 5'd2;
    end else if (mbits > 5'd24) begin
      m_sat = 5'd24;
    end else begin
      m_sat = mbits;
    end
    range_full = (24'd1 << (m_sat - 5'd1)) - 24'd1;
  end

  always_ff @(posedge clk) begin
    den <= 39'(lv) * 39'(cfg.g[0]);
  end

  always_comb begin
    cfg.den    = den;
    cfg.irange = range_full[22:0];
    for (int i = 0; i < GAIN_REGS; i++) begin
      cfg.g[i] = (gain[i] == '0) ? 8'd1 : gain[i];
    end
    if (gcount == '0) begin
      cfg.n = 3'd1;
    end else if (gcount > 3'(LANES)) begin
      cfg.n = 3'(LANES);
    end else begin
      cfg.n = gcount;
    end
  end
endmodule
`default_nettype wire

/* rtl/grq_div.sv */
`default_nettype none
module grq_div #(
  parameter int QW = 24,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [63:0]   num,
  input  logic [63:0]   den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);
  logic          vld [QW+1];
  logic [63:0]   rem [QW];
  logic [63:0]   dv  [QW];
  logic [QW-1:0] q   [QW+1];
  logic          of  [QW+1];
  logic [SW-1:0] sd  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      of[0]  <= num >= (den << QW);
      sd[0]  <= side;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int K = QW - j;
    logic ge;
    assign ge = rem[j-1] >= (dv[j-1] << K);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q[j]  <= q[j-1] | (QW'(ge) << K);
        of[j] <= of[j-1];
        sd[j] <= sd[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[j] <= ge ? rem[j-1] - (dv[j-1] << K) : rem[j-1];
          dv[j]  <= dv[j-1];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign ovf       = of[QW];
  assign side_out  = sd[QW];
endmodule
`default_nettype wire
